// ===== sv/qft_pkg.sv =====
// qft_pkg: shared types and constants for the quoted field tokenizer
// no dependencies; imported by every module of the block
`default_nettype none

package qft_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_SEP_CHARS  = 2'd0;
  localparam logic [1:0] CFG_SEP_COUNT  = 2'd1;
  localparam logic [1:0] CFG_MAX_TOKENS = 2'd2;

  // configuration reset values
  localparam logic [63:0] SEP_CHARS_RST  = 64'h20;
  localparam logic [3:0]  SEP_COUNT_RST  = 4'd1;
  localparam logic [7:0]  MAX_TOKENS_RST = 8'd255;

  // double quote character
  localparam logic [7:0] QUOTE_CH = 8'h22;

  // one input character
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  // one result
  typedef struct packed {
    logic        has_token;
    logic [7:0]  token_number;
    logic [9:0]  start_pos;
    logic [10:0] token_length;
    logic        quoted;
    logic        mismatched_quote;
    logic        done_res;
    logic [7:0]  token_count;
    logic        too_long;
  } out_item_t;

  // scanner step outcome handed to the top level
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } qft_step_t;

endpackage

`default_nettype wire

// ===== sv/quoted_field_tokenizer.sv =====
// quoted_field_tokenizer: an accepted request goes through the input register, then the result register, to out_valid
// throughput 1 character per cycle; the input register feeds the scan step
// and the result register in the next cycle, so only out_ready backpressure
// on a character that produces a result stalls the input
// reset: synchronous active low, configuration back to space / 1 slot / 255,
// scan state cleared at once, no clearing pass
`default_nettype none

module quoted_field_tokenizer
  import qft_pkg::*;
#(
  parameter int MAX_LEN   = 1024,
  parameter int SEP_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);

  logic [63:0] sep_chars_r;
  logic [3:0]  sep_count_r;
  logic [7:0]  max_tokens_r;

  logic        s1_valid_r;
  in_item_t    s1_data_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic        is_sep;
  qft_step_t   step_res;
  logic        out_free;
  logic        s1_adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_chars_r  <= SEP_CHARS_RST;
      sep_count_r  <= SEP_COUNT_RST;
      max_tokens_r <= MAX_TOKENS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEP_CHARS:  sep_chars_r  <= cfg_wdata;
        CFG_SEP_COUNT:  sep_count_r  <= cfg_wdata[3:0];
        CFG_MAX_TOKENS: max_tokens_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // separator compare on the registered character
  qft_sep_match #(
    .SEP_SLOTS (SEP_SLOTS)
  ) u_sep (
    .sep_chars (sep_chars_r),
    .sep_count (sep_count_r),
    .ch        (s1_data_r.ch),
    .is_sep    (is_sep)
  );

  // scan step
  qft_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .item       (s1_data_r),
    .is_sep     (is_sep),
    .max_tokens (max_tokens_r),
    .res        (step_res)
  );

  // flow control: a character without a result never waits on the output
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!step_res.emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && step_res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && step_res.emit) begin
      out_data_r <= step_res.item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result without a token only closes a string
  a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.has_token) |-> out_data_r.done_res)
    else $error("tokenless result not marked done");

  // an unclosed quote is reported only at the end and only as quoted
  a_mismatch_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.mismatched_quote) |->
      (out_data_r.done_res && out_data_r.quoted && out_data_r.has_token))
    else $error("mismatched quote outside final result");

  // a counted token's index is below the running count
  a_number_below_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.has_token && !out_data_r.mismatched_quote) |->
      (out_data_r.token_number < out_data_r.token_count))
    else $error("token number not below token count");

  // the input stalls only behind a held character
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

// ===== sv/qft_sep_match.sv =====
// qft_sep_match: compares one character against the configured separator slots
// depends on qft_pkg (nothing used beyond the import convention)
`default_nettype none

module qft_sep_match
  import qft_pkg::*;
#(
  parameter int SEP_SLOTS = 8
) (
  input  wire logic [63:0] sep_chars,
  input  wire logic [3:0]  sep_count,
  input  wire logic [7:0]  ch,
  output logic             is_sep
);

  // one comparator per slot, slots above the count are masked off
  always_comb begin
    is_sep = 1'b0;
    for (int k = 0; k < SEP_SLOTS; k++) begin
      if ((4'(k) < sep_count) && (sep_chars[8*k +: 8] == ch)) begin
        is_sep = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/qft_core.sv =====
// qft_core: per-string scan state and the single-step token decision
// depends on qft_pkg for item types and the quote constant
`default_nettype none

module qft_core
  import qft_pkg::*;
#(
  parameter int MAX_LEN = 1024
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire in_item_t   item,
  input  wire logic       is_sep,
  input  wire logic [7:0] max_tokens,
  output qft_step_t       res
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam logic [PW-1:0] LEN_LIM  = PW'(MAX_LEN);
  localparam logic [PW-1:0] LAST_POS = PW'(MAX_LEN - 1);

  typedef enum logic [1:0] {
    MODE_BETWEEN = 2'd0,
    MODE_PLAIN   = 2'd1,
    MODE_QUOTED  = 2'd2
  } mode_t;

  mode_t         mode_r, mode_nxt;
  logic [PW-1:0] pos_cnt_r, pos_cnt_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [7:0]    found_r, found_nxt;
  logic          over_r, over_nxt;

  logic          at_limit;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] tok_end;
  logic [PW-1:0] tok_len;
  logic          active;
  logic          is_quote;
  logic          has;
  logic          quo;
  logic          mis;

  // position counting with saturation at the length limit
  always_comb begin
    at_limit    = (pos_cnt_r >= LEN_LIM);
    pos         = at_limit ? LAST_POS : pos_cnt_r;
    pos_cnt_nxt = at_limit ? pos_cnt_r : pos_cnt_r + PW'(1);
    over_nxt    = over_r | at_limit;
    pos_inc     = pos + PW'(1);
  end

  // token decision for the current character
  always_comb begin
    active    = (found_r < max_tokens);
    is_quote  = (item.ch == QUOTE_CH);
    has       = 1'b0;
    quo       = 1'b0;
    mis       = 1'b0;
    tok_end   = '0;
    start_nxt = start_r;
    mode_nxt  = mode_r;
    found_nxt = found_r;
    tok_len   = '0;
    if (active) begin
      unique case (mode_r)
        MODE_PLAIN: begin
          if (is_sep) begin
            has     = 1'b1;
            tok_end = pos;
          end else if (item.last) begin
            has     = 1'b1;
            tok_end = pos_inc;
          end
        end
        MODE_QUOTED: begin
          if (is_quote) begin
            has     = 1'b1;
            quo     = 1'b1;
            tok_end = pos;
          end else if (item.last) begin
            has     = 1'b1;
            quo     = 1'b1;
            mis     = 1'b1;
            tok_end = pos_inc;
          end
        end
        default: begin
          if (!is_sep) begin
            if (is_quote) begin
              // content starts after the quote, clamped to the last position
              start_nxt = (pos == LAST_POS) ? LAST_POS : pos_inc;
              mode_nxt  = MODE_QUOTED;
              if (item.last) begin
                has     = 1'b1;
                quo     = 1'b1;
                mis     = 1'b1;
                tok_end = start_nxt;
              end
            end else begin
              start_nxt = pos;
              mode_nxt  = MODE_PLAIN;
              if (item.last) begin
                has     = 1'b1;
                tok_end = pos_inc;
              end
            end
          end
        end
      endcase
      if (has) begin
        tok_len   = (tok_end > start_nxt) ? tok_end - start_nxt : '0;
        found_nxt = mis ? found_r : found_r + 8'd1;
        mode_nxt  = MODE_BETWEEN;
      end
    end
  end

  // result fields
  always_comb begin
    res.emit                  = has | item.last;
    res.item.has_token        = has;
    res.item.token_number     = has ? found_r : 8'd0;
    res.item.start_pos        = has ? 10'(start_nxt) : 10'd0;
    res.item.token_length     = 11'(tok_len);
    res.item.quoted           = quo;
    res.item.mismatched_quote = mis;
    res.item.done_res         = item.last;
    res.item.token_count      = found_nxt;
    res.item.too_long         = over_nxt;
  end

  // scan state, cleared at the end of each string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_BETWEEN;
      pos_cnt_r <= '0;
      start_r   <= '0;
      found_r   <= '0;
      over_r    <= 1'b0;
    end else if (step) begin
      if (item.last) begin
        mode_r    <= MODE_BETWEEN;
        pos_cnt_r <= '0;
        start_r   <= '0;
        found_r   <= '0;
        over_r    <= 1'b0;
      end else begin
        mode_r    <= mode_nxt;
        pos_cnt_r <= pos_cnt_nxt;
        start_r   <= start_nxt;
        found_r   <= found_nxt;
        over_r    <= over_nxt;
      end
    end
  end

  // a counted token never leaves the scanner in a token mode
  a_mode_after_token: assert property (@(posedge clk) disable iff (!rst_n)
    (step && has) |=> (mode_r == MODE_BETWEEN))
    else $error("scan mode not cleared after a token");

  // end of string returns all state to reset
  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last) |=> (pos_cnt_r == '0 && found_r == 8'd0 && !over_r))
    else $error("string state not cleared after final character");

  // the token count never passes the configured limit
  a_found_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (step && found_nxt != found_r) |-> (found_r < max_tokens))
    else $error("token counted beyond max_tokens");

endmodule

`default_nettype wire
